### src/wcon_pkg.sv
`default_nettype none

package wcon_pkg;

  // field widths fixed by the packet and sample formats
  localparam int unsigned NODE_W  = 8;
  localparam int unsigned SEL_W   = 8;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned SIDX_W  = 3;
  localparam int unsigned LEVEL_W = 2;

  // address value after reset
  localparam logic [NODE_W-1:0] NODE_ID_RESET = 8'd1;

  // output selector that asks for a report, also the terminator's input id
  localparam logic [SEL_W-1:0] REPORT_SEL = 8'hFF;

  // item codes
  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // result codes
  typedef enum logic {
    KIND_LEVELS  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_t;

endpackage : wcon_pkg

`default_nettype wire

### src/window_comparator_output_node_core.sv
`default_nettype none

// Sensor node packet handler with window-comparator outputs.
// Items are offered on start and taken on a clock edge where start is high
// and busy is low. op selects a packet (dest_node, output_sel, input_sel,
// low_bound, high_bound) or a sensor sample (sample_index, sample_value).
// Each result is shown for exactly one cycle with strobe high; the
// receiver cannot stall, so nothing is ever held back on the result side.
// Any item but a report request gives one levels result via the input
// register, commit stage and result register; one such item may be taken
// every cycle while busy is low. A report request (addressed packet,
// output selector 0xFF) gives NUM_INPUTS payload beats on consecutive
// cycles, then one terminating beat with last high; busy stays high while
// the request waits and the payload counter walks the sample store one
// entry a cycle. The user must write the node address on the cfg channel
// (always ready) only while the block is idle; the block does not enforce
// it. Synchronous reset clears all windows and samples to zero, sets the
// node address to 1 and empties the pipeline.
module window_comparator_output_node_core #(
  parameter int unsigned NUM_INPUTS  = 5,
  parameter int unsigned NUM_OUTPUTS = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // item channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          op,
  input  wire logic [wcon_pkg::NODE_W-1:0]   dest_node,
  input  wire logic [wcon_pkg::SEL_W-1:0]    output_sel,
  input  wire logic [wcon_pkg::SEL_W-1:0]    input_sel,
  input  wire logic [wcon_pkg::VALUE_W-1:0]  low_bound,
  input  wire logic [wcon_pkg::VALUE_W-1:0]  high_bound,
  input  wire logic [wcon_pkg::SIDX_W-1:0]   sample_index,
  input  wire logic [wcon_pkg::VALUE_W-1:0]  sample_value,
  // configuration channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [wcon_pkg::NODE_W-1:0]   cfg_data,
  // result channel
  output logic                               strobe,
  output logic                               kind,
  output logic [wcon_pkg::LEVEL_W-1:0]       out_levels,
  output logic [wcon_pkg::NODE_W-1:0]        tx_node,
  output logic [wcon_pkg::SEL_W-1:0]         tx_input_id,
  output logic [wcon_pkg::VALUE_W-1:0]       tx_value,
  output logic                               last
);

  import wcon_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_INPUTS + 1);
  localparam int unsigned IDX_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_INPUTS);

  // configuration
  logic [NODE_W-1:0] node_id;

  // state stores
  logic [VALUE_W-1:0] window_low  [NUM_OUTPUTS][NUM_INPUTS];
  logic [VALUE_W-1:0] window_high [NUM_OUTPUTS][NUM_INPUTS];
  logic [VALUE_W-1:0] samples     [NUM_INPUTS];

  // input register
  logic               a_valid;
  logic               a_op;
  logic [NODE_W-1:0]  a_dest;
  logic [SEL_W-1:0]   a_osel;
  logic [SEL_W-1:0]   a_isel;
  logic [VALUE_W-1:0] a_low;
  logic [VALUE_W-1:0] a_high;
  logic [SIDX_W-1:0]  a_sidx;
  logic [VALUE_W-1:0] a_sval;

  // decode of the held item
  logic a_addressed;
  logic a_report;
  logic a_win_wr;
  logic a_smp_wr;

  // commit stage: levels pending or report walk
  logic             b_levels;
  logic             b_report;
  logic [CNT_W-1:0] b_cnt;

  // combinational results
  logic [LEVEL_W-1:0] levels;
  logic [VALUE_W-1:0] pay_value;
  logic               pay_end;

  // configuration port always takes a beat
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id <= NODE_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      node_id <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      a_op   <= op;
      a_dest <= dest_node;
      a_osel <= output_sel;
      a_isel <= input_sel;
      a_low  <= low_bound;
      a_high <= high_bound;
      a_sidx <= sample_index;
      a_sval <= sample_value;
    end
  end

  // decode
  always_comb begin
    a_addressed = (a_op == OP_PACKET) && (a_dest == node_id);
    a_report    = a_valid && a_addressed && (a_osel == REPORT_SEL);
    a_win_wr    = a_valid && a_addressed && (a_osel < SEL_W'(NUM_OUTPUTS))
                  && (a_isel < SEL_W'(NUM_INPUTS));
    a_smp_wr    = a_valid && (a_op == OP_SAMPLE)
                  && ({{(SEL_W-SIDX_W){1'b0}}, a_sidx} < SEL_W'(NUM_INPUTS));
  end

  // busy while a report waits to start or its walk has not reached the end
  assign busy = a_report || (b_report && (b_cnt != CNT_END));

  // window and sample stores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
        for (int j = 0; j < NUM_INPUTS; j++) begin
          window_low[i][j]  <= '0;
          window_high[i][j] <= '0;
        end
      end
      for (int j = 0; j < NUM_INPUTS; j++) begin
        samples[j] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
        for (int j = 0; j < NUM_INPUTS; j++) begin
          if (a_win_wr && (a_osel == SEL_W'(i)) && (a_isel == SEL_W'(j))) begin
            window_low[i][j]  <= a_low;
            window_high[i][j] <= a_high;
          end
        end
      end
      for (int j = 0; j < NUM_INPUTS; j++) begin
        if (a_smp_wr && ({{(SEL_W-SIDX_W){1'b0}}, a_sidx} == SEL_W'(j))) begin
          samples[j] <= a_sval;
        end
      end
    end
  end

  // commit stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_levels <= 1'b0;
      b_report <= 1'b0;
      b_cnt    <= '0;
    end else begin
      b_levels <= a_valid && !a_report;
      if (a_report) begin
        b_report <= 1'b1;
        b_cnt    <= '0;
      end else if (b_report) begin
        if (b_cnt == CNT_END) begin
          b_report <= 1'b0;
        end else begin
          b_cnt <= b_cnt + 1'b1;
        end
      end
    end
  end

  // window comparison over the reported outputs
  always_comb begin
    levels = '0;
    for (int i = 0; (i < LEVEL_W) && (i < NUM_OUTPUTS); i++) begin
      levels[i] = 1'b1;
      for (int j = 0; j < NUM_INPUTS; j++) begin
        if ((samples[j] < window_low[i][j]) || (samples[j] > window_high[i][j])) begin
          levels[i] = 1'b0;
        end
      end
    end
  end

  // payload value for the current walk position
  always_comb begin
    pay_end   = (b_cnt == CNT_END);
    pay_value = '0;
    if (!pay_end) begin
      pay_value = samples[b_cnt[IDX_W-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= b_levels || b_report;
    end
  end

  always_ff @(posedge clk) begin
    if (b_levels) begin
      kind        <= KIND_LEVELS;
      out_levels  <= levels;
      tx_node     <= '0;
      tx_input_id <= '0;
      tx_value    <= '0;
      last        <= 1'b1;
    end else if (b_report) begin
      kind        <= KIND_PAYLOAD;
      out_levels  <= '0;
      tx_node     <= node_id;
      tx_input_id <= pay_end ? REPORT_SEL : SEL_W'(b_cnt);
      tx_value    <= pay_value;
      last        <= pay_end;
    end
  end

endmodule : window_comparator_output_node_core

`default_nettype wire
